FILE: sv/mkr_pkg.sv
package mkr_pkg;

  localparam int RAW_W       = 12;
  localparam int KNOB_W      = 2;
  localparam int LEVEL_W     = 5;
  localparam int SECTOR_W    = 4;
  localparam int NUM_OFFSETS = 8;
  localparam int OFF_IW      = 3;
  localparam int CFG_IDX_W   = 4;

  typedef struct packed {
    logic [KNOB_W-1:0] knob;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  raw_x;
    logic              button_level;
  } scan_t;

  typedef struct packed {
    logic [KNOB_W-1:0]  knob_id;
    logic               present;
    logic               inserted;
    logic               removed;
    logic               pressed;
    logic               lock_on;
    logic [LEVEL_W-1:0] level;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [RAW_W-1:0]     value;
  } cfg_t;

endpackage

FILE: sv/mkr_stream_if.sv
interface mkr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/mkr_sector.sv
module mkr_sector #(
  parameter int DW = 13
) (
  input  logic signed [DW-1:0]               x,
  input  logic signed [DW-1:0]               y,
  output logic [mkr_pkg::SECTOR_W-1:0]       sector
);

  localparam int PW = DW + 26;
  localparam logic [25:0] TAN22_Q24 = 26'd6949350;
  localparam logic [25:0] TAN67_Q24 = 26'd40503782;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;
  localparam logic [1:0] SUB_3 = 2'd3;
  localparam logic [mkr_pkg::SECTOR_W-1:0] SECTOR_ORIGIN = 4'd8;
  localparam logic [mkr_pkg::SECTOR_W-1:0] SECTOR_FULL   = 4'd15;

  logic signed [DW-1:0] u;
  logic signed [DW-1:0] v;
  logic signed [DW-1:0] a_s;
  logic signed [DW-1:0] b_s;
  logic [DW-1:0]        a;
  logic [DW-1:0]        b;
  logic [1:0]           quad;
  logic [1:0]           sub;
  logic [PW-1:0]        bs;
  logic [PW-1:0]        p22;
  logic [PW-1:0]        p67;

  // rotate (-x, -y) into the first quadrant
  always_comb begin
    u = -x;
    v = -y;
    priority if (u > 0 && v >= 0) begin
      quad = QUAD_0;
      a_s  = u;
      b_s  = v;
    end else if (u <= 0 && v > 0) begin
      quad = QUAD_1;
      a_s  = v;
      b_s  = -u;
    end else if (u < 0 && v <= 0) begin
      quad = QUAD_2;
      a_s  = -u;
      b_s  = -v;
    end else begin
      quad = QUAD_3;
      a_s  = -v;
      b_s  = u;
    end
  end

  assign a   = $unsigned(a_s);
  assign b   = $unsigned(b_s);
  assign bs  = PW'(b) << 24;
  assign p22 = PW'(a) * PW'(TAN22_Q24);
  assign p67 = PW'(a) * PW'(TAN67_Q24);

  always_comb begin
    priority if (bs < p22) begin
      sub = SUB_0;
    end else if (b < a) begin
      sub = SUB_1;
    end else if (bs < p67) begin
      sub = SUB_2;
    end else begin
      sub = SUB_3;
    end
  end

  always_comb begin
    priority if (x == '0 && y == '0) begin
      sector = SECTOR_ORIGIN;
    end else if (y == '0 && x < 0) begin
      sector = SECTOR_FULL;
    end else begin
      sector = {quad, sub};
    end
  end

endmodule

FILE: sv/magnetic_knob_reader_core.sv
// Magnetic knob reader.
// Channels: cfg (sink) writes the eight offset registers, index 2k for knob k's
// y sensor and 2k+1 for its x sensor; other indexes are dropped. cfg is always
// ready. scan (sink) takes one scan of one knob per item; result (source)
// returns one item per scan, in order, with presence, insert/remove, press and
// lock flags and the bar level.
// Path: an accepted scan is held in the input register, then its result in the
// result register. Throughput: one item per cycle while result is not stalled,
// set by the single result stage, which reads and writes the per-knob state
// in the same cycle.
// Reset clears offsets, per-knob state and both valid flags; no clearing pass.
// When result is stalled the result register holds, the input register still
// takes one more scan, and scan.ready drops once both are full.
// Scans for a knob index at or above KNOBS return zero flags and level and
// leave all state alone.
module magnetic_knob_reader_core #(
  parameter int SEGMENTS        = 16,
  parameter int KNOBS           = 4,
  parameter int ADC_BITS        = 12,
  parameter int FIELD_THRESHOLD = 20
) (
  input  logic         clk,
  input  logic         rst,
  mkr_stream_if.sink   cfg,
  mkr_stream_if.sink   scan,
  mkr_stream_if.source result
);

  localparam int EFF_BITS = (ADC_BITS < mkr_pkg::RAW_W) ? ADC_BITS : mkr_pkg::RAW_W;
  localparam int DW       = EFF_BITS + 1;
  localparam int MAG_W    = (2 * DW + 1 > 24) ? 2 * DW + 1 : 24;
  localparam logic [MAG_W-1:0] THR_SQ = MAG_W'(FIELD_THRESHOLD * FIELD_THRESHOLD);
  localparam int LVF_W    = mkr_pkg::SECTOR_W + $clog2(SEGMENTS) + 2;
  localparam logic [LVF_W-1:0] SEG_L = LVF_W'(SEGMENTS);

  logic [mkr_pkg::RAW_W-1:0] offsets [mkr_pkg::NUM_OFFSETS];

  mkr_pkg::scan_t   s1;
  logic             s1_valid;
  mkr_pkg::result_t out_item;
  logic             out_valid;
  logic             advance;

  logic [KNOBS-1:0]                  was_present;
  logic [KNOBS-1:0]                  lock_flag;
  logic [KNOBS-1:0]                  button_prev;
  logic [mkr_pkg::SECTOR_W-1:0]      held_sector [KNOBS];

  logic signed [DW-1:0]       ry;
  logic signed [DW-1:0]       rx;
  logic signed [DW-1:0]       oy;
  logic signed [DW-1:0]       ox;
  logic signed [DW-1:0]       dy;
  logic signed [DW-1:0]       dx;
  logic signed [2*DW-1:0]     sq_y;
  logic signed [2*DW-1:0]     sq_x;
  logic [MAG_W-1:0]           mag;
  logic                       present;
  logic [mkr_pkg::SECTOR_W-1:0] sector;

  logic                         knob_ok;
  logic                         cur_was;
  logic                         cur_lock;
  logic                         cur_bprev;
  logic [mkr_pkg::SECTOR_W-1:0] cur_held;
  logic                         btn_down;
  logic                         press;
  logic                         lock_next;
  logic [mkr_pkg::SECTOR_W-1:0] held_next;
  logic                         ins;
  logic                         rem;
  logic [LVF_W-1:0]             scaled;
  logic [LVF_W-1:0]             level_full;
  mkr_pkg::result_t             res;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mkr_pkg::NUM_OFFSETS; i++) begin
        offsets[i] <= '0;
      end
    end else if (cfg.valid && cfg.data.idx < mkr_pkg::CFG_IDX_W'(mkr_pkg::NUM_OFFSETS)) begin
      offsets[cfg.data.idx[mkr_pkg::OFF_IW-1:0]] <= cfg.data.value;
    end
  end

  // handshake
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign scan.ready   = !s1_valid || advance;
  assign result.valid = out_valid;
  assign result.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1 <= scan.data;
    end
  end

  // offset correction and field strength
  assign ry = signed'(DW'(s1.raw_y[EFF_BITS-1:0]));
  assign rx = signed'(DW'(s1.raw_x[EFF_BITS-1:0]));
  assign oy = signed'(DW'(offsets[{s1.knob, 1'b0}][EFF_BITS-1:0]));
  assign ox = signed'(DW'(offsets[{s1.knob, 1'b1}][EFF_BITS-1:0]));
  assign dy = ry - oy;
  assign dx = rx - ox;
  assign sq_y = dy * dy;
  assign sq_x = dx * dx;
  assign mag  = MAG_W'($unsigned(sq_x)) + MAG_W'($unsigned(sq_y));
  assign present = mag > THR_SQ;

  mkr_sector #(.DW(DW)) u_sector (
    .x      (dx),
    .y      (dy),
    .sector (sector)
  );

  // per-knob state read
  assign knob_ok = int'(s1.knob) < KNOBS;

  always_comb begin
    cur_was   = 1'b0;
    cur_lock  = 1'b0;
    cur_bprev = 1'b0;
    cur_held  = '0;
    for (int i = 0; i < KNOBS; i++) begin
      if (s1.knob == mkr_pkg::KNOB_W'(i)) begin
        cur_was   = was_present[i];
        cur_lock  = lock_flag[i];
        cur_bprev = button_prev[i];
        cur_held  = held_sector[i];
      end
    end
  end

  assign btn_down = !s1.button_level;
  assign press    = btn_down && !cur_bprev;

  // toggle lock first, then sample sector, then clear lock on insertion
  always_comb begin
    lock_next = cur_lock;
    held_next = cur_held;
    ins       = 1'b0;
    rem       = 1'b0;
    if (present) begin
      lock_next = cur_lock ^ press;
      if (!lock_next) begin
        held_next = sector;
      end
      if (!cur_was) begin
        ins       = 1'b1;
        lock_next = 1'b0;
      end
    end else begin
      rem = cur_was;
    end
  end

  assign scaled     = (LVF_W'(held_next) * SEG_L) >> 4;
  assign level_full = scaled + LVF_W'(1);

  always_comb begin
    res         = '0;
    res.knob_id = s1.knob;
    if (knob_ok) begin
      res.present  = present;
      res.inserted = ins;
      res.removed  = rem;
      res.pressed  = press;
      res.lock_on  = lock_next;
      if (present || lock_next) begin
        res.level = (level_full > SEG_L) ? mkr_pkg::LEVEL_W'(SEG_L)
                                         : mkr_pkg::LEVEL_W'(level_full);
      end
    end
  end

  // per-knob state write
  always_ff @(posedge clk) begin
    if (rst) begin
      was_present <= '0;
      lock_flag   <= '0;
      button_prev <= '0;
      for (int i = 0; i < KNOBS; i++) begin
        held_sector[i] <= '0;
      end
    end else if (advance && knob_ok) begin
      for (int i = 0; i < KNOBS; i++) begin
        if (s1.knob == mkr_pkg::KNOB_W'(i)) begin
          was_present[i] <= present;
          lock_flag[i]   <= lock_next;
          button_prev[i] <= btn_down;
          held_sector[i] <= held_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("stalled scan dropped from input register");

  a_insert_unlocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.inserted |-> out_item.present && !out_item.lock_on)
    else $error("insertion left the lock set");

  a_level_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.level != '0 |-> out_item.present || out_item.lock_on)
    else $error("level shown with magnet absent and knob unlocked");

  a_state_follows: assert property (@(posedge clk) disable iff (rst)
    advance && knob_ok && present |=> was_present[$past(s1.knob)])
    else $error("presence not recorded for knob");

endmodule
